@@ hdl/rbe_pkg.sv @@
// Constants, request codes and payload types of the byte-wise rANS encoder.
package rbe_pkg;

   localparam int SCALE_BITS    = 12;
   localparam int ALPHABET_SIZE = 256;

   localparam int TYPE_W  = 2;
   localparam int SYM_W   = 8;
   localparam int FREQ_W  = 13;
   localparam int CUM_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int STATE_W = 32;

   // Coder state after reset and after a flush: 2^23.
   localparam logic [STATE_W-1:0] LOW_BOUND = STATE_W'(1) << 23;

   // Renorm bound is ((2^23 >> SCALE_BITS) << 8) * freq = freq << BOUND_SHIFT.
   localparam int BOUND_SHIFT = 23 - SCALE_BITS + 8;
   localparam int BOUND_W     = FREQ_W + BOUND_SHIFT;

   localparam int IDX_W     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int ENTRY_W   = FREQ_W + CUM_W;
   localparam int DIV_STEPS = STATE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int STATE_BYTES = STATE_W / BYTE_W;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ENCODE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_FLUSH  = 2'd2;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [SYM_W-1:0]  symbol;
      logic [FREQ_W-1:0] frequency;
      logic [CUM_W-1:0]  cumulative;
   } req_data_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_state_byte;
      logic              error;
      logic              last_of_run;
   } rsp_data_type;

endpackage

@@ hdl/rbe_if.sv @@
// Valid/ready channels for encoder requests and emitted bytes.
interface rbe_req_if;
   logic                       valid;
   logic                       ready;
   rbe_pkg::req_data_type      data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rbe_rsp_if;
   logic                       valid;
   logic                       ready;
   rbe_pkg::rsp_data_type      data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/rans_byte_encoder.sv @@
// Byte-wise rANS encoder: symbol table, renorm sequencer and radix-2 divider.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  req_ch    | in  | valid/ready        | req_type, symbol, frequency, cumulative
//  rsp_ch    | out | valid/ready        | out_byte, is_state_byte, error, last_of_run
//
//  Table load is written as the request is taken. Encode steps: table read,
//  check, renorm, 32 restoring divider steps (one quotient bit per cycle) and
//  update. A zero-frequency encode ends after the check with one error result.
//  Flush: take the request, then emit the four state bytes. Empty flush and
//  code 3: handled as the request is taken.
//  Reset is synchronous; the coder state returns to 2^23, the table is not cleared.
//  A stalled rsp_ch holds the sequencer wherever a byte has to be emitted; the
//  output register lets the next request be taken while the last byte waits.
module rans_byte_encoder (
   input  logic        clock,
   input  logic        reset,
   rbe_req_if.sink     req_ch,
   rbe_rsp_if.source   rsp_ch
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_RENORM = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_FLUSH  = 3'd5;

   // symbol table: {frequency, cumulative}
   logic [rbe_pkg::ENTRY_W-1:0] tbl_mem [rbe_pkg::ALPHABET_SIZE];

   logic [2:0]                      state_ff, state_in;
   logic [rbe_pkg::STATE_W-1:0]     x_ff, x_in;
   logic [rbe_pkg::FREQ_W-1:0]      rem_ff, rem_in;
   logic [rbe_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            pend_v_ff, pend_v_in;
   logic [rbe_pkg::BYTE_W-1:0]      pend_ff, pend_in;
   logic                            any_ff, any_in;
   logic                            bad_ff;
   logic [rbe_pkg::ENTRY_W-1:0]     entry_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   rbe_pkg::rsp_data_type           rsp_data_ff, rsp_data_in;

   logic                            req_fire;
   logic                            sym_ok;
   logic [rbe_pkg::IDX_W-1:0]       sym_idx;
   logic                            out_free;
   logic                            rsp_load;
   logic [rbe_pkg::FREQ_W-1:0]      freq;
   logic [rbe_pkg::CUM_W-1:0]       cum;
   logic [rbe_pkg::BOUND_W-1:0]     bound;
   logic                            renorm_ge;
   logic [rbe_pkg::FREQ_W:0]        trial;
   logic                            div_ge;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign sym_ok  = {1'b0, req_ch.data.symbol} < (rbe_pkg::SYM_W + 1)'(rbe_pkg::ALPHABET_SIZE);
   assign sym_idx = req_ch.data.symbol[rbe_pkg::IDX_W-1:0];

   assign freq = entry_ff[rbe_pkg::ENTRY_W-1 -: rbe_pkg::FREQ_W];
   assign cum  = entry_ff[rbe_pkg::CUM_W-1:0];

   // renorm compare: state against freq * 2^19
   assign bound     = {freq, rbe_pkg::BOUND_SHIFT'(0)};
   assign renorm_ge = rbe_pkg::BOUND_W'(x_ff) >= bound;

   // restoring divider step: remainder shifts in the next dividend bit
   assign trial  = {rem_ff, x_ff[rbe_pkg::STATE_W-1]};
   assign div_ge = trial >= {1'b0, freq};

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Table write and registered table read.
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.data.req_type == rbe_pkg::REQ_LOAD && sym_ok) begin
         tbl_mem[sym_idx] <= {req_ch.data.frequency, req_ch.data.cumulative};
      end
      if (req_fire && req_ch.data.req_type == rbe_pkg::REQ_ENCODE) begin
         entry_ff <= tbl_mem[sym_idx];
         bad_ff   <= !sym_ok;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      any_in       = any_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_ch.data.req_type == rbe_pkg::REQ_ENCODE) begin
                  state_in = ST_CHECK;
               end else if (req_ch.data.req_type == rbe_pkg::REQ_FLUSH) begin
                  if (any_ff) begin
                     state_in = ST_FLUSH;
                     cnt_in   = '0;
                  end else begin
                     x_in = rbe_pkg::LOW_BOUND;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_CHECK: begin
            if (bad_ff || freq == '0) begin
               // zero frequency or index beyond alphabet: one error result
               if (out_free) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '{out_byte: '0, is_state_byte: 1'b0,
                                  error: 1'b1, last_of_run: 1'b1};
                  state_in    = ST_IDLE;
               end
            end else begin
               pend_v_in = 1'b0;
               state_in  = ST_RENORM;
            end
         end

         ST_RENORM: begin
            // a byte is held back until the next renorm test, so its last flag is known
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '{out_byte: pend_ff, is_state_byte: 1'b0,
                                  error: 1'b0, last_of_run: !renorm_ge};
               end
               if (renorm_ge) begin
                  pend_v_in = 1'b1;
                  pend_in   = x_ff[rbe_pkg::BYTE_W-1:0];
                  x_in      = x_ff >> rbe_pkg::BYTE_W;
               end else begin
                  pend_v_in = 1'b0;
                  rem_in    = '0;
                  cnt_in    = '0;
                  state_in  = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            rem_in = div_ge ? rbe_pkg::FREQ_W'(trial - {1'b0, freq})
                            : trial[rbe_pkg::FREQ_W-1:0];
            x_in   = {x_ff[rbe_pkg::STATE_W-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rbe_pkg::CNT_W'(rbe_pkg::DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            // x' = q * 2^SCALE_BITS + cum + rem
            x_in     = (x_ff << rbe_pkg::SCALE_BITS)
                     + rbe_pkg::STATE_W'(cum) + rbe_pkg::STATE_W'(rem_ff);
            any_in   = 1'b1;
            state_in = ST_IDLE;
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{out_byte: x_ff[rbe_pkg::BYTE_W-1:0], is_state_byte: 1'b1,
                               error: 1'b0,
                               last_of_run: cnt_ff == rbe_pkg::CNT_W'(rbe_pkg::STATE_BYTES - 1)};
               x_in        = x_ff >> rbe_pkg::BYTE_W;
               cnt_in      = cnt_ff + 1'b1;
               if (cnt_ff == rbe_pkg::CNT_W'(rbe_pkg::STATE_BYTES - 1)) begin
                  x_in     = rbe_pkg::LOW_BOUND;
                  any_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_ff         <= rbe_pkg::LOW_BOUND;
         any_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         any_ff       <= any_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

`ifndef SYNTHESIS
   // an error result is always alone and never a state byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.error |-> rsp_ch.data.last_of_run && !rsp_ch.data.is_state_byte)
      else $error("error result without last_of_run or marked as state byte");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < freq)
      else $error("divider remainder not below frequency");

   // an encode request closes the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.data.req_type == rbe_pkg::REQ_ENCODE |=> !req_ch.ready)
      else $error("request taken while an encode is in progress");

   // renorm leaves the state below the bound before the division starts
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RENORM && state_in == ST_DIV |-> !renorm_ge)
      else $error("division started with state above renorm bound");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the byte-wise rANS encoder: random and directed requests.
module testbench;
   import rbe_pkg::*;

   // Cycles with no handshake on either channel before the run is declared hung.
   // The worst legal quiet spell is the deliberate receiver hold-off plus one
   // encode plus the longest sender gap, well below this figure.
   localparam int QUIET_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 420;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   // Tracks the coder and the symbol table, and holds the bytes still owed.
   class rans_byte_tracker;
      logic [STATE_W-1:0] coder_x;
      logic [FREQ_W-1:0]  freq_tab [ALPHABET_SIZE];
      logic [CUM_W-1:0]   cum_tab  [ALPHABET_SIZE];
      bit                 coded_any;
      rsp_data_type       owed_bytes [$];
      int unsigned        mismatches, bytes_checked;
      int unsigned        n_loads, n_encodes, n_errors, n_flushes, n_ignored;

      function new();
         coder_x   = LOW_BOUND;
         coded_any = 1'b0;
      endfunction

      function automatic rsp_data_type make_byte(logic [BYTE_W-1:0] value, bit is_state,
                                                 bit err, bit last);
         rsp_data_type b;
         b.out_byte      = value;
         b.is_state_byte = is_state;
         b.error         = err;
         b.last_of_run   = last;
         return b;
      endfunction

      function void note_request(req_data_type r);
         logic [63:0]       x, f, bnd;
         logic [BYTE_W-1:0] renorm [4];
         int                n;
         case (r.req_type)
            REQ_LOAD: begin
               n_loads++;
               if (int'(r.symbol) < ALPHABET_SIZE) begin
                  freq_tab[r.symbol] = r.frequency;
                  cum_tab[r.symbol]  = r.cumulative;
               end
            end
            REQ_ENCODE: begin
               n_encodes++;
               if (int'(r.symbol) >= ALPHABET_SIZE || freq_tab[r.symbol] == '0) begin
                  // zero frequency: lone error byte, coder untouched
                  n_errors++;
                  owed_bytes.push_back(make_byte('0, 1'b0, 1'b1, 1'b1));
               end else begin
                  x   = 64'(coder_x);
                  f   = 64'(freq_tab[r.symbol]);
                  bnd = f << BOUND_SHIFT;
                  n   = 0;
                  while (x >= bnd && n < 4) begin
                     renorm[n] = x[7:0];
                     n++;
                     x = x >> 8;
                  end
                  for (int i = 0; i < n; i++)
                     owed_bytes.push_back(make_byte(renorm[i], 1'b0, 1'b0, i == n - 1));
                  x = ((x / f) << SCALE_BITS) + 64'(cum_tab[r.symbol]) + (x % f);
                  coder_x   = x[STATE_W-1:0];
                  coded_any = 1'b1;
               end
            end
            REQ_FLUSH: begin
               n_flushes++;
               if (coded_any) begin
                  for (int i = 0; i < STATE_BYTES; i++)
                     owed_bytes.push_back(make_byte(coder_x[8*i +: 8], 1'b1, 1'b0,
                                                    i == STATE_BYTES - 1));
               end
               coder_x   = LOW_BOUND;
               coded_any = 1'b0;
            end
            default: n_ignored++;
         endcase
      endfunction

      function void check_byte(rsp_data_type got);
         rsp_data_type want;
         bytes_checked++;
         if (owed_bytes.size() == 0) begin
            $error("unexpected result: out_byte %0h is_state_byte %0b error %0b last %0b",
                   got.out_byte, got.is_state_byte, got.error, got.last_of_run);
            mismatches++;
            return;
         end
         want = owed_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.is_state_byte !== want.is_state_byte) begin
            $error("is_state_byte: expected %0b, got %0b", want.is_state_byte,
                   got.is_state_byte);
            mismatches++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, got.error);
            mismatches++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return owed_bytes.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   rbe_req_if req_ch ();
   rbe_rsp_if rsp_ch ();

   rans_byte_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rans_byte_tracker tracker = new();

   int unsigned requests_taken = 0;
   int unsigned quiet_cycles   = 0;
   int          sender_stall_pct = 0;
   bit          long_hold_done = 1'b0;
   bit          entry_loaded [ALPHABET_SIZE];
   int          loaded_syms [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap lengths: usually drawn from the shortest range, now and then a long lull.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 85)      return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 15);
      else                return $urandom_range(30, 80);
   endfunction

   // Frequencies lean towards the small values that force renormalisation,
   // with the zero and full-scale extremes mixed in.
   function automatic logic [FREQ_W-1:0] pick_frequency();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)       return '0;
      else if (roll < 10) return FREQ_W'(1 << SCALE_BITS);
      else if (roll < 20) return FREQ_W'($urandom_range(1, 4));
      else if (roll < 45) return FREQ_W'($urandom_range(1, 64));
      else                return FREQ_W'($urandom_range(1, 4095));
   endfunction

   function automatic logic [SYM_W-1:0] pick_index();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)      return '0;
      else if (roll < 20) return '1;
      else                return SYM_W'($urandom_range(0, 255));
   endfunction

   function automatic req_data_type make_req(logic [TYPE_W-1:0] kind, logic [SYM_W-1:0] sym,
                                             logic [FREQ_W-1:0] freq, logic [CUM_W-1:0] cum);
      req_data_type r;
      r.req_type   = kind;
      r.symbol     = sym;
      r.frequency  = freq;
      r.cumulative = cum;
      return r;
   endfunction

   task automatic idle_sender(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Offer one request and hold it until the block takes it. valid stays high
   // into the next request unless a gap is drawn here.
   task automatic send_request(req_data_type r);
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(r);
      requests_taken++;
      if ($urandom_range(99) < sender_stall_pct)
         idle_sender(idle_length());
   endtask

   task automatic send_load(logic [SYM_W-1:0] sym, logic [FREQ_W-1:0] freq,
                            logic [CUM_W-1:0] cum);
      send_request(make_req(REQ_LOAD, sym, freq, cum));
      if (!entry_loaded[sym]) begin
         entry_loaded[sym] = 1'b1;
         loaded_syms.push_back(int'(sym));
      end
   endtask

   task automatic send_encode(logic [SYM_W-1:0] sym);
      send_request(make_req(REQ_ENCODE, sym, FREQ_W'($urandom_range(0, 4096)),
                            CUM_W'($urandom_range(0, 4095))));
   endtask

   task automatic send_flush();
      send_request(make_req(REQ_FLUSH, SYM_W'($urandom_range(0, 255)),
                            FREQ_W'($urandom_range(0, 4096)), CUM_W'($urandom_range(0, 4095))));
   endtask

   // Code 3 carries random fields and must leave no trace.
   task automatic send_unused();
      send_request(make_req(REQ_UNUSED, SYM_W'($urandom_range(0, 255)),
                            FREQ_W'($urandom_range(0, 4096)), CUM_W'($urandom_range(0, 4095))));
   endtask

   // Sender stops and waits for every owed byte; it always waits for a clock
   // edge first, so valid is never lowered and raised in the same step.
   task automatic wait_for_owed_bytes();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Result side: checks every accepted byte, then decides ready for the next
   // cycle. Stall density is drawn anew from three levels so quiet stretches occur,
   // and one long hold-off lets the block back up onto its request port.
   initial begin
      int          stall_left;
      int          rx_stall_pct;
      int unsigned rx_cycle;
      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      rx_stall_pct = 0;
      rx_cycle     = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_byte(rsp_ch.data);
         rx_cycle++;
         if (rx_cycle % 256 == 0) begin
            case ($urandom_range(2))
               0:       rx_stall_pct = 0;
               1:       rx_stall_pct = 15;
               default: rx_stall_pct = 40;
            endcase
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!long_hold_done && requests_taken >= 120) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD - 1;
            rsp_ch.ready  <= 1'b0;
         end else if ($urandom_range(99) < rx_stall_pct) begin
            stall_left    = idle_length() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Hang detector: any handshake on either side clears the count.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("hung: no handshake for %0d cycles, %0d bytes still owed",
                     quiet_cycles, tracker.outstanding());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int  random_items;
      int  n_load, n_enc, roll;
      bit  drain_pause_done;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      random_items     = 0;
      drain_pause_done = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      sender_stall_pct = 20;
      send_flush();                        // empty flush straight after reset
      send_unused();
      send_load(8'd0,   13'd4096, 12'd0);    // full-scale frequency
      send_load(8'd255, 13'd1,    12'd4095); // minimum frequency, top cumulative
      send_load(8'd1,   13'd0,    12'h5a5);  // zero frequency entry
      send_load(8'd2,   13'd2048, 12'habc);
      send_encode(8'd0);                   // no renormalisation
      send_encode(8'd255);                 // one renorm byte
      send_encode(8'd255);                 // two renorm bytes
      send_encode(8'd1);                   // zero-frequency error
      send_encode(8'd2);
      send_flush();                        // four state bytes
      send_flush();                        // second flush is empty
      send_encode(8'd1);                   // error alone must not arm the flush
      send_flush();
      send_load(8'd3, 13'h0fff, 12'hfff);
      send_load(8'd4, 13'h0aaa, 12'h555);
      send_encode(8'd3);
      send_encode(8'd4);
      send_unused();                       // ignored mid-stream
      send_encode(8'd4);
      send_flush();

      // ---- random sessions: load some entries, encode a run, flush ----
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(2))
            0:       sender_stall_pct = 0;
            1:       sender_stall_pct = 20;
            default: sender_stall_pct = 50;
         endcase

         if (!drain_pause_done && requests_taken >= 250) begin
            wait_for_owed_bytes();
            drain_pause_done = 1'b1;
         end

         n_load = $urandom_range(1, 6);
         for (int i = 0; i < n_load; i++) begin
            send_load(pick_index(), pick_frequency(), CUM_W'($urandom_range(0, 4095)));
            random_items++;
         end

         n_enc = $urandom_range(1, 12);
         for (int i = 0; i < n_enc; i++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               send_unused();
            end else if (roll < 10) begin
               send_load(pick_index(), pick_frequency(), CUM_W'($urandom_range(0, 4095)));
               random_items++;
            end
            send_encode(SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]));
            random_items++;
         end

         // mostly flush; sometimes carry the state on, sometimes flush twice
         roll = $urandom_range(99);
         if (roll < 85) begin
            send_flush();
            random_items++;
         end else if (roll >= 95) begin
            send_flush();
            send_flush();
            random_items += 2;
         end
      end

      // ---- wind-down ----
      wait_for_owed_bytes();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d loads, %0d encodes (%0d zero-frequency), %0d flushes",
               requests_taken, tracker.n_loads, tracker.n_encodes, tracker.n_errors,
               tracker.n_flushes);
      $display("%0d ignored code-3 requests, %0d result bytes checked, %0d mismatches",
               tracker.n_ignored, tracker.bytes_checked, tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
